>>> hdl/sccc_pkg.sv
`timescale 1ns / 1ps

package sccc_pkg;

    // one frame payload byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // one report
    typedef struct packed {
        logic        report_kind;
        logic [7:0]  component_id;
        logic [15:0] segment_length;
        logic        crc_ok;
    } report_item_t;

    localparam logic REPORT_COMPONENT = 1'b0;
    localparam logic REPORT_ENCRYPTED = 1'b1;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [2:0]  HEADER_BYTES  = 3'd4;
    localparam logic [2:0]  HEADER_CRYPT  = 3'd3;
    localparam logic [3:0]  COVER_MAX     = 4'd13;

    // component parse phases
    localparam logic [2:0] PH_ID      = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_CRC_HI  = 3'd3;
    localparam logic [2:0] PH_CRC_LO  = 3'd4;
    localparam logic [2:0] PH_COVERED = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;

    // byte-wise crc-ccitt update, polynomial 0x1021
    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] x;
        begin
            x = {acc[7:0], acc[15:8]} ^ {8'h00, b};
            x = x ^ {12'h000, x[7:4]};
            x = x ^ {x[3:0], 12'h000} ^ {3'b000, x[7:0], 5'b00000};
            return x;
        end
    endfunction

endpackage

>>> hdl/sccc_parser.sv
`timescale 1ns / 1ps

module sccc_parser
    import sccc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  byte_item_t   item,
    output logic         res_valid,
    output report_item_t res
);

    logic [2:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic        skip_reg,     skip_next;
    logic [2:0]  phase_reg,    phase_next;
    logic [7:0]  id_reg,       id_next;
    logic [15:0] len_reg,      len_next;
    logic [15:0] crc_rx_reg,   crc_rx_next;
    logic [15:0] acc_reg,      acc_next;
    logic [15:0] rem_reg,      rem_next;
    logic [3:0]  cov_reg,      cov_next;
    logic [15:0] crc_byte;
    logic [3:0]  cov_len;
    logic        crc_match;

    assign crc_byte = crc_update(acc_reg, item.data_byte);
    assign cov_len  = (len_reg < {12'h000, COVER_MAX}) ? len_reg[3:0] : COVER_MAX;

    // next state and report for the current byte
    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        skip_next    = skip_reg;
        phase_next   = phase_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        crc_rx_next  = crc_rx_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        cov_next     = cov_reg;
        res_valid    = 1'b0;
        res.report_kind    = REPORT_COMPONENT;
        res.component_id   = 8'h00;
        res.segment_length = 16'h0000;
        res.crc_ok         = 1'b0;

        if (skip_reg)
        begin
            // rest of frame ignored
        end
        else if (hdr_cnt_reg < HEADER_BYTES)
        begin
            if (hdr_cnt_reg == HEADER_CRYPT && item.data_byte != 8'h00)
            begin
                skip_next       = 1'b1;
                res_valid       = 1'b1;
                res.report_kind = REPORT_ENCRYPTED;
            end
            hdr_cnt_next = hdr_cnt_reg + 3'd1;
        end
        else
        begin
            case (phase_reg)
                PH_ID:
                begin
                    id_next    = item.data_byte;
                    acc_next   = crc_update(CRC_INIT, item.data_byte);
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {item.data_byte, 8'h00};
                    acc_next   = crc_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {len_reg[15:8], item.data_byte};
                    acc_next   = crc_byte;
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    crc_rx_next = {item.data_byte, 8'h00};
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    crc_rx_next = {crc_rx_reg[15:8], item.data_byte};
                    cov_next    = cov_len;
                    rem_next    = len_reg - {12'h000, cov_len};
                    if (cov_len != 4'd0)
                        phase_next = PH_COVERED;
                    else
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_ID;
                    end
                end
                PH_COVERED:
                begin
                    acc_next = crc_byte;
                    cov_next = cov_reg - 4'd1;
                    if (cov_next == 4'd0)
                    begin
                        if (rem_reg == 16'h0000)
                        begin
                            res_valid  = 1'b1;
                            phase_next = PH_ID;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                end
                default:
                begin
                    rem_next = rem_reg - 16'd1;
                    if (rem_next == 16'h0000)
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_ID;
                    end
                end
            endcase
        end

        // component report fields
        if (res.report_kind == REPORT_COMPONENT)
        begin
            res.component_id   = id_next;
            res.segment_length = len_next;
            res.crc_ok         = crc_match;
        end

        // frame end puts the parser back to its start
        if (item.last_byte)
        begin
            hdr_cnt_next = 3'd0;
            skip_next    = 1'b0;
            phase_next   = PH_ID;
            id_next      = 8'h00;
            len_next     = 16'h0000;
            crc_rx_next  = 16'h0000;
            acc_next     = CRC_INIT;
            rem_next     = 16'h0000;
            cov_next     = 4'd0;
        end
    end

    // compare uses the crc including this byte only while data is hashed
    always_comb
    begin
        case (phase_reg)
            PH_CRC_LO:
                crc_match = ((acc_reg ^ CRC_INIT) == {crc_rx_reg[15:8], item.data_byte});
            PH_COVERED:
                crc_match = ((crc_byte ^ CRC_INIT) == crc_rx_reg);
            default:
                crc_match = ((acc_reg ^ CRC_INIT) == crc_rx_reg);
        endcase
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= 3'd0;
            skip_reg    <= 1'b0;
            phase_reg   <= PH_ID;
            id_reg      <= 8'h00;
            len_reg     <= 16'h0000;
            crc_rx_reg  <= 16'h0000;
            acc_reg     <= CRC_INIT;
            rem_reg     <= 16'h0000;
            cov_reg     <= 4'd0;
        end
        else if (take)
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            skip_reg    <= skip_next;
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            crc_rx_reg  <= crc_rx_next;
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            cov_reg     <= cov_next;
        end
    end

endmodule

>>> hdl/sccc_out_buf.sv
`timescale 1ns / 1ps

module sccc_out_buf
    import sccc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  report_item_t push_item,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output report_item_t out_item
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    report_item_t out_item_reg;
    report_item_t skid_item_reg;
    logic         load;

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign load      = !out_valid_reg || out_ready;

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // item payloads
    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= skid_valid_reg ? skid_item_reg : push_item;
        else if (push)
            skid_item_reg <= push_item;
    end

endmodule

>>> hdl/service_component_crc_checker_top.sv
`timescale 1ns / 1ps
// a report is valid in the cycle after the byte that completes it is accepted,
// when the output register is free or being read in that cycle
// throughput: one byte per cycle while byte_ready is high; crc and parse update per byte
// an output register plus one skid entry keep bytes flowing while a report waits
// reset: rst_n is asynchronous, active low; the parser returns to frame start
// and both output stages are emptied

module service_component_crc_checker_top
    import sccc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  byte_item_t   byte_item,
    output logic         report_valid,
    input  logic         report_ready,
    output report_item_t report_item
);

    logic         take;
    logic         res_valid;
    report_item_t res;
    logic         space;

    assign byte_ready = space;
    assign take       = byte_valid && space;

    // frame and component parser
    sccc_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (byte_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    sccc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_item (res),
        .space     (space),
        .out_valid (report_valid),
        .out_ready (report_ready),
        .out_item  (report_item)
    );

endmodule
